/* rtl/baxo_pkg.sv */
// ----------------------------------------------------------------------------
// baxo_pkg
// Shared widths, reset constants, register codes and the tracker bundle for
// the box axis projection overlap block.
// ----------------------------------------------------------------------------
`default_nettype none

package baxo_pkg;

  // Field widths
  localparam int unsigned COORD_W = 32;  // Q16.16 corner coordinate
  localparam int unsigned AXIS_W  = 18;  // Q2.16 axis component
  localparam int unsigned PROD_W  = COORD_W + AXIS_W;  // one product
  localparam int unsigned PROJ_W  = 52;  // projection and trackers, Q.32
  localparam int unsigned OVL_W   = 53;  // overlap result, Q21.32
  localparam int unsigned CIDX_W  = 2;   // configuration register index

  // Tracker reset values: low starts at most positive, high at most negative
  localparam logic signed [PROJ_W-1:0] TRACK_MAX = {1'b0, {(PROJ_W-1){1'b1}}};
  localparam logic signed [PROJ_W-1:0] TRACK_MIN = {1'b1, {(PROJ_W-1){1'b0}}};

  // Axis reset: unit vector along x
  localparam logic signed [AXIS_W-1:0] AXIS_X_RST = AXIS_W'(65536);
  localparam logic signed [AXIS_W-1:0] AXIS_Y_RST = '0;
  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = '0;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_AXIS_X = 2'd0,
    REG_AXIS_Y = 2'd1,
    REG_AXIS_Z = 2'd2
  } cfg_reg_e;

  // Interval extremes of both boxes
  typedef struct packed {
    logic signed [PROJ_W-1:0] a_lo;
    logic signed [PROJ_W-1:0] a_hi;
    logic signed [PROJ_W-1:0] b_lo;
    logic signed [PROJ_W-1:0] b_hi;
  } track_t;

endpackage : baxo_pkg

`default_nettype wire

/* rtl/baxo_proj.sv */
// ----------------------------------------------------------------------------
// baxo_proj
// Projects one corner onto the axis: three registered products, then a
// registered three-way sum.
// ----------------------------------------------------------------------------
`default_nettype none

module baxo_proj
  import baxo_pkg::*;
(
  input  wire                             clk_i,
  input  wire                             prod_en_i,
  input  wire                             sum_en_i,
  input  wire  logic signed [COORD_W-1:0] pt_x_i,
  input  wire  logic signed [COORD_W-1:0] pt_y_i,
  input  wire  logic signed [COORD_W-1:0] pt_z_i,
  input  wire  logic signed [AXIS_W-1:0]  axis_x_i,
  input  wire  logic signed [AXIS_W-1:0]  axis_y_i,
  input  wire  logic signed [AXIS_W-1:0]  axis_z_i,
  output logic signed [PROJ_W-1:0]        proj_o
);

  localparam int unsigned EXT_W = PROJ_W - PROD_W;

  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [PROJ_W-1:0] proj_d, proj_q;

  // Products, exact at full width
  assign px_d = PROD_W'(pt_x_i) * PROD_W'(axis_x_i);
  assign py_d = PROD_W'(pt_y_i) * PROD_W'(axis_y_i);
  assign pz_d = PROD_W'(pt_z_i) * PROD_W'(axis_z_i);

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  // Dot product sum, sign extended to tracker width
  assign proj_d = {{EXT_W{px_q[PROD_W-1]}}, px_q}
                + {{EXT_W{py_q[PROD_W-1]}}, py_q}
                + {{EXT_W{pz_q[PROD_W-1]}}, pz_q};

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule : baxo_proj

`default_nettype wire

/* rtl/baxo_track.sv */
// ----------------------------------------------------------------------------
// baxo_track
// Running min/max of both boxes' projections and the corner counter. At the
// last corner the final extremes are captured and the trackers restart.
// ----------------------------------------------------------------------------
`default_nettype none

module baxo_track
  import baxo_pkg::*;
#(
  parameter int unsigned CORNERS = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            take_i,
  input  wire  logic signed [PROJ_W-1:0] proj_a_i,
  input  wire  logic signed [PROJ_W-1:0] proj_b_i,
  output logic                           last_o,
  output track_t                         snap_o
);

  localparam int unsigned CNT_W = $clog2(CORNERS);

  logic [CNT_W-1:0] cnt_d, cnt_q;
  track_t           trk_d, trk_q, upd;
  track_t           snap_q;

  // Fold in the current corner pair
  always_comb begin
    upd      = trk_q;
    if (proj_a_i < trk_q.a_lo) upd.a_lo = proj_a_i;
    if (proj_a_i > trk_q.a_hi) upd.a_hi = proj_a_i;
    if (proj_b_i < trk_q.b_lo) upd.b_lo = proj_b_i;
    if (proj_b_i > trk_q.b_hi) upd.b_hi = proj_b_i;
  end

  assign last_o = (cnt_q == CNT_W'(CORNERS - 1));

  // Next tracker state: restart after the last corner
  always_comb begin
    trk_d = trk_q;
    cnt_d = cnt_q;
    if (take_i) begin
      if (last_o) begin
        trk_d = '{a_lo: TRACK_MAX, a_hi: TRACK_MIN, b_lo: TRACK_MAX, b_hi: TRACK_MIN};
        cnt_d = '0;
      end else begin
        trk_d = upd;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '{a_lo: TRACK_MAX, a_hi: TRACK_MIN, b_lo: TRACK_MAX, b_hi: TRACK_MIN};
      cnt_q <= '0;
    end else begin
      trk_q <= trk_d;
      cnt_q <= cnt_d;
    end
  end

  // Final extremes of the box pair
  always_ff @(posedge clk_i) begin
    if (take_i && last_o) begin
      snap_q <= upd;
    end
  end

  assign snap_o = snap_q;

endmodule : baxo_track

`default_nettype wire

/* rtl/baxo_result.sv */
// ----------------------------------------------------------------------------
// baxo_result
// Overlap of the two projected intervals: registered differences, then the
// smaller one into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module baxo_result
  import baxo_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      diff_en_i,
  input  wire                      out_en_i,
  input  wire  track_t             snap_i,
  output logic signed [OVL_W-1:0]  overlap_o
);

  logic signed [OVL_W-1:0] d1_d, d2_d, d1_q, d2_q;
  logic signed [OVL_W-1:0] ovl_d, ovl_q;

  // maxA - minB and maxB - minA, one bit wider so they stay exact
  assign d1_d = {snap_i.a_hi[PROJ_W-1], snap_i.a_hi} - {snap_i.b_lo[PROJ_W-1], snap_i.b_lo};
  assign d2_d = {snap_i.b_hi[PROJ_W-1], snap_i.b_hi} - {snap_i.a_lo[PROJ_W-1], snap_i.a_lo};

  always_ff @(posedge clk_i) begin
    if (diff_en_i) begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  assign ovl_d = (d1_q < d2_q) ? d1_q : d2_q;

  always_ff @(posedge clk_i) begin
    if (out_en_i) begin
      ovl_q <= ovl_d;
    end
  end

  assign overlap_o = ovl_q;

endmodule : baxo_result

`default_nettype wire

/* rtl/box_axis_projection_overlap.sv */
// ----------------------------------------------------------------------------
// box_axis_projection_overlap
// Separating-axis overlap of two boxes along one configured axis.
// ----------------------------------------------------------------------------
// Input channel: one transfer per corner pair (box A corner, same-numbered
// box B corner), Q16.16. After CORNERS transfers one result transfer carries
// overlap = min(maxA - minB, maxB - minA) in Q21.32; negative separates.
// Throughput: one corner pair per cycle while in_stall_o is low. The result of a
// pair passes through the product, sum, tracker, difference and output register
// stages after the edge that takes its last corner.
// The axis is set through the write port (index 0..2 = x, y, z, Q2.16); the user
// writes it only while idle, which the block does not enforce; index 3 is ignored.
// Reset clears all stage valids, the corner count and the trackers, and sets
// the axis to (1, 0, 0).
// When the receiver stalls, the result holds in the output register and
// corners keep flowing into the trackers; in_stall_o rises only when a later
// result has filled every stage behind the held one.
// ----------------------------------------------------------------------------
`default_nettype none

module box_axis_projection_overlap
  import baxo_pkg::*;
#(
  parameter int unsigned CORNERS = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write port
  input  wire                            cfg_we_i,
  input  wire  logic [CIDX_W-1:0]        cfg_idx_i,
  input  wire  logic [AXIS_W-1:0]        cfg_wdata_i,
  // corner pair input
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  logic signed [COORD_W-1:0] first_x_i,
  input  wire  logic signed [COORD_W-1:0] first_y_i,
  input  wire  logic signed [COORD_W-1:0] first_z_i,
  input  wire  logic signed [COORD_W-1:0] second_x_i,
  input  wire  logic signed [COORD_W-1:0] second_y_i,
  input  wire  logic signed [COORD_W-1:0] second_z_i,
  // overlap result
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic signed [OVL_W-1:0]        overlap_o
);

  logic signed [AXIS_W-1:0]  axis_x_q, axis_y_q, axis_z_q;
  logic signed [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [PROJ_W-1:0]  proj_a, proj_b;
  track_t                    snap;

  logic v0_q, v1_q, v2_q, v3_q, v4_q, vo_q;
  logic v0_d, v1_d, v2_d, v3_d, v4_d, vo_d;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic take2, trk_last;

  // Axis registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= AXIS_X_RST;
      axis_y_q <= AXIS_Y_RST;
      axis_z_q <= AXIS_Z_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AXIS_X: axis_x_q <= cfg_wdata_i;
        REG_AXIS_Y: axis_y_q <= cfg_wdata_i;
        REG_AXIS_Z: axis_z_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Stage advance: a stage moves when empty or when its successor moves.
  // The tracker stage absorbs every corner but the last one.
  assign rdy_o = !vo_q || !out_stall_i;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign take2 = v2_q && (!trk_last || rdy3);
  assign rdy2  = !v2_q || take2;
  assign rdy1  = !v1_q || rdy2;
  assign rdy0  = !v0_q || rdy1;

  assign in_stall_o = !rdy0;

  assign v0_d = rdy0  ? in_valid_i          : v0_q;
  assign v1_d = rdy1  ? v0_q                : v1_q;
  assign v2_d = rdy2  ? v1_q                : v2_q;
  assign v3_d = rdy3  ? (take2 && trk_last) : v3_q;
  assign v4_d = rdy4  ? v3_q                : v4_q;
  assign vo_d = rdy_o ? v4_q                : vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      vo_q <= vo_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      ax_q <= first_x_i;
      ay_q <= first_y_i;
      az_q <= first_z_i;
      bx_q <= second_x_i;
      by_q <= second_y_i;
      bz_q <= second_z_i;
    end
  end

  // Projections of both corners
  baxo_proj u_proj_a (
    .clk_i     (clk_i),
    .prod_en_i (rdy1),
    .sum_en_i  (rdy2),
    .pt_x_i    (ax_q),
    .pt_y_i    (ay_q),
    .pt_z_i    (az_q),
    .axis_x_i  (axis_x_q),
    .axis_y_i  (axis_y_q),
    .axis_z_i  (axis_z_q),
    .proj_o    (proj_a)
  );

  baxo_proj u_proj_b (
    .clk_i     (clk_i),
    .prod_en_i (rdy1),
    .sum_en_i  (rdy2),
    .pt_x_i    (bx_q),
    .pt_y_i    (by_q),
    .pt_z_i    (bz_q),
    .axis_x_i  (axis_x_q),
    .axis_y_i  (axis_y_q),
    .axis_z_i  (axis_z_q),
    .proj_o    (proj_b)
  );

  // Interval trackers
  baxo_track #(
    .CORNERS (CORNERS)
  ) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take2),
    .proj_a_i (proj_a),
    .proj_b_i (proj_b),
    .last_o   (trk_last),
    .snap_o   (snap)
  );

  // Overlap and output register
  baxo_result u_result (
    .clk_i     (clk_i),
    .diff_en_i (rdy4),
    .out_en_i  (rdy_o),
    .snap_i    (snap),
    .overlap_o (overlap_o)
  );

  assign out_valid_o = vo_q;

`ifndef ASSERT_OFF
  // Input only backs up behind a held result with every stage full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vo_q && out_stall_i && v4_q && v3_q && v2_q && trk_last))
    else $error("input stalled without a full pipeline behind a held result");

  // A finished pair restarts the corner count
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take2 && trk_last) |=> !trk_last)
    else $error("corner count did not restart after the last corner");

  // An accepted corner is in the input register in the next cycle
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v0_q)
    else $error("accepted transfer lost at the input register");
`endif

endmodule : box_axis_projection_overlap

`default_nettype wire

/* sim/box_axis_projection_overlap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_axis_projection_overlap_tb
// Self-checking bench for the box axis projection overlap block. Corner
// pairs go in through the valid/stall channel. An in-bench interval tracker
// computes the expected overlap after each eighth corner, and every result
// transfer is compared against it in order. Runs directed corner and axis
// cases, then random boxes over several axis settings and idling mixes.
// ----------------------------------------------------------------------------

module box_axis_projection_overlap_tb;
  import baxo_pkg::*;

  localparam int unsigned CORNERS         = 8;
  localparam int unsigned DRAIN_CYCLES    = 12;         // drain margin after the last expected result
  localparam int unsigned RAND_PHASES     = 24;
  localparam int unsigned PAIRS_PER_PHASE = 10;
  localparam int unsigned LIMIT_NS        = 2_000_000;
  localparam int unsigned MAX_PRINTS      = 20;

  // write index with no register behind it
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [AXIS_W-1:0]  AXIS_MIN  = {1'b1, {(AXIS_W-1){1'b0}}};
  localparam logic signed [AXIS_W-1:0]  AXIS_MAX  = {1'b0, {(AXIS_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // one corner of box A and the same-numbered corner of box B
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
  } corner_pair_t;

  // DUT inputs, all known from time zero
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]         cfg_idx_i   = '0;
  logic [AXIS_W-1:0]         cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic signed [COORD_W-1:0] first_x_i   = '0;
  logic signed [COORD_W-1:0] first_y_i   = '0;
  logic signed [COORD_W-1:0] first_z_i   = '0;
  logic signed [COORD_W-1:0] second_x_i  = '0;
  logic signed [COORD_W-1:0] second_y_i  = '0;
  logic signed [COORD_W-1:0] second_z_i  = '0;
  logic                      out_stall_i = 1'b0;

  // DUT outputs
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [OVL_W-1:0]   overlap_o;

  // idling mix, percent per cycle
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  // tracker copy: axis, interval extremes, corners taken into current pair
  logic signed [AXIS_W-1:0] axis_x_m = AXIS_X_RST;
  logic signed [AXIS_W-1:0] axis_y_m = AXIS_Y_RST;
  logic signed [AXIS_W-1:0] axis_z_m = AXIS_Z_RST;
  longint      a_lo;
  longint      a_hi;
  longint      b_lo;
  longint      b_hi;
  int unsigned corners_taken;

  logic signed [OVL_W-1:0] overlap_q [$];
  logic signed [OVL_W-1:0] want_overlap;

  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned pairs_sent = 0;
  int unsigned axis_settings = 0;

  box_axis_projection_overlap #(
    .CORNERS(CORNERS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .first_z_i  (first_z_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .second_z_i (second_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .overlap_o  (overlap_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Interval tracker
  // ---------------------------------------------------------------------------

  function automatic void clear_trackers();
    a_lo = longint'(TRACK_MAX);
    a_hi = longint'(TRACK_MIN);
    b_lo = longint'(TRACK_MAX);
    b_hi = longint'(TRACK_MIN);
    corners_taken = 0;
  endfunction

  // exact dot product, Q16.16 x Q2.16 -> Q.32
  function automatic longint project(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y,
                                     logic signed [COORD_W-1:0] z);
    return longint'(x) * longint'(axis_x_m) + longint'(y) * longint'(axis_y_m)
         + longint'(z) * longint'(axis_z_m);
  endfunction

  // fold one accepted corner pair in; the eighth one yields an overlap
  function automatic void track_corner(corner_pair_t c);
    longint pa;
    longint pb;
    longint d1;
    longint d2;
    longint r;
    pa = project(c.ax, c.ay, c.az);
    pb = project(c.bx, c.by, c.bz);
    if (pa < a_lo) a_lo = pa;
    if (pa > a_hi) a_hi = pa;
    if (pb < b_lo) b_lo = pb;
    if (pb > b_hi) b_hi = pb;
    corners_taken++;
    if (corners_taken == CORNERS) begin
      d1 = a_hi - b_lo;
      d2 = b_hi - a_lo;
      r  = (d1 < d2) ? d1 : d2;
      overlap_q.push_back(r[OVL_W-1:0]);
      pairs_sent++;
      clear_trackers();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // compare each result transfer with the oldest expected overlap
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (overlap_q.size() == 0) begin
        report_mismatch($sformatf("overlap %0d with nothing expected", overlap_o));
      end else begin
        want_overlap = overlap_q.pop_front();
        results_checked++;
        if (overlap_o !== want_overlap)
          report_mismatch($sformatf("overlap got %0d want %0d", overlap_o, want_overlap));
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // one corner pair transfer, with random idle cycles ahead of it
  task automatic send_corner(corner_pair_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i  <= c.ax;
    first_y_i  <= c.ay;
    first_z_i  <= c.az;
    second_x_i <= c.bx;
    second_y_i <= c.by;
    second_z_i <= c.bz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_corner(c);
  endtask

  // stop sending, let every expected result out and the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write; leaves the write enable high for a following write
  task automatic put_reg(logic [CIDX_W-1:0] idx, logic signed [AXIS_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_AXIS_X: axis_x_m = val;
      REG_AXIS_Y: axis_y_m = val;
      REG_AXIS_Z: axis_z_m = val;
      default: ;
    endcase
  endtask

  task automatic set_axis(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                          logic signed [AXIS_W-1:0] z);
    wait_idle();
    put_reg(REG_AXIS_X, x);
    put_reg(REG_AXIS_Y, y);
    put_reg(REG_AXIS_Z, z);
    cfg_we_i <= 1'b0;
    axis_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [COORD_W-1:0] extreme_coord(int unsigned i);
    case (i % 8)
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      5:       return 32'sh0001_0000;
      6:       return 32'shFFFF_0000;
      default: return 32'sh5555_5555;
    endcase
  endfunction

  // uniform in about [-span, span], wrapping at the coordinate width
  function automatic logic signed [COORD_W-1:0] jitter(int unsigned span);
    return COORD_W'($urandom_range(2 * span)) - COORD_W'(span);
  endfunction

  // mostly well-formed boxes near or far apart; some noise and extremes
  task automatic send_random_pair();
    corner_pair_t              c;
    logic signed [COORD_W-1:0] ca [3];
    logic signed [COORD_W-1:0] cb [3];
    logic signed [COORD_W-1:0] ha [3];
    logic signed [COORD_W-1:0] hb [3];
    int unsigned               spread;
    int unsigned               kind;
    kind   = $urandom_range(9);
    spread = 1 << $urandom_range(30);
    for (int k = 0; k < 3; k++) begin
      ca[k] = $urandom;
      cb[k] = ($urandom_range(1) == 1) ? ca[k] + jitter(spread) : COORD_W'($urandom);
      ha[k] = $urandom_range(spread);
      hb[k] = $urandom_range(spread);
    end
    for (int i = 0; i < CORNERS; i++) begin
      if (kind == 0) begin
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (kind == 1) begin
        c = '{extreme_coord($urandom), extreme_coord($urandom), extreme_coord($urandom),
              extreme_coord($urandom), extreme_coord($urandom), extreme_coord($urandom)};
      end else begin
        c.ax = i[0] ? ca[0] + ha[0] : ca[0] - ha[0];
        c.ay = i[1] ? ca[1] + ha[1] : ca[1] - ha[1];
        c.az = i[2] ? ca[2] + ha[2] : ca[2] - ha[2];
        c.bx = i[0] ? cb[0] + hb[0] : cb[0] - hb[0];
        c.by = i[1] ? cb[1] + hb[1] : cb[1] - hb[1];
        c.bz = i[2] ? cb[2] + hb[2] : cb[2] - hb[2];
      end
      send_corner(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset axis (1, 0, 0) with extreme coordinates on every field
  task automatic test_reset_axis();
    for (int i = 0; i < CORNERS; i++)
      send_corner('{extreme_coord(i), extreme_coord(i + 3), extreme_coord(i + 5),
                    extreme_coord(7 - i), extreme_coord(i + 1), extreme_coord(i + 6)});
  endtask

  // most negative axis against full-scale corners: largest projections
  task automatic test_axis_extremes();
    set_axis(AXIS_MIN, AXIS_MIN, AXIS_MIN);
    for (int i = 0; i < CORNERS; i++)
      send_corner('{i[0] ? COORD_MIN : COORD_MAX, i[0] ? COORD_MIN : COORD_MAX,
                    i[0] ? COORD_MIN : COORD_MAX, i < 4 ? COORD_MIN : extreme_coord(i),
                    i < 4 ? COORD_MIN : extreme_coord(i), i < 4 ? COORD_MIN : COORD_MAX});
  endtask

  // axis rewritten halfway through a pair; projections taken so far stay put.
  // A write to the unused index must change nothing.
  task automatic test_axis_change_mid_pair();
    set_axis(AXIS_MAX, AXIS_MIN, AXIS_MAX);
    for (int i = 0; i < CORNERS / 2; i++)
      send_corner('{extreme_coord(i), extreme_coord(i + 2), extreme_coord(i + 4),
                    extreme_coord(i + 1), extreme_coord(i + 3), extreme_coord(i + 5)});
    wait_idle();
    put_reg(REG_AXIS_Y, AXIS_MAX);
    put_reg(REG_UNUSED, AXIS_W'($urandom));
    put_reg(REG_AXIS_Z, '0);
    cfg_we_i <= 1'b0;
    for (int i = CORNERS / 2; i < CORNERS; i++)
      send_corner('{extreme_coord(i), extreme_coord(i + 2), extreme_coord(i + 4),
                    extreme_coord(i + 1), extreme_coord(i + 3), extreme_coord(i + 5)});
  endtask

  // random boxes across axis settings and idling mixes
  task automatic test_random_phases();
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p / 4)
        1:       set_axis('0, '0, '0);
        2:       set_axis(AXIS_MIN, AXIS_MIN, AXIS_MIN);
        3:       set_axis(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        4:       set_axis(AXIS_W'($urandom_range(2)) - AXIS_W'(1),
                          AXIS_W'($urandom_range(2)) - AXIS_W'(1),
                          AXIS_W'($urandom_range(2)) - AXIS_W'(1));
        default: set_axis(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
      endcase
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      repeat (PAIRS_PER_PHASE) send_random_pair();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_trackers();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_axis();
    test_axis_extremes();
    test_axis_change_mid_pair();
    test_random_phases();
    wait_idle();

    $display("Covered %0d box pairs over %0d axis settings and four idling mixes;",
             pairs_sent, axis_settings);
    $display("checked %0d overlap results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("box_axis_projection_overlap_tb OK");
    end else begin
      $display("box_axis_projection_overlap_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d overlap results outstanding", overlap_q.size());
    $display("box_axis_projection_overlap_tb NOT OK");
    $finish;
  end

endmodule
